// ===== hw/rtl/msq_pkg.sv =====
// Shared types and constants for the motion state qualifier.
package msq_pkg;

  localparam int unsigned VelW     = 32;
  localparam int unsigned MagW     = VelW + 1;
  localparam int unsigned ThrW     = 22;
  localparam int unsigned RunW     = 8;
  localparam int unsigned RateW    = 16;
  localparam int unsigned WinW     = 16;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned ScoreW   = 18;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;

  // 0.01 in Q15.16, truncated: motion limit for command samples
  localparam logic [MagW-1:0] CmdMotionLimit = MagW'(655);

  localparam logic [ThrW-1:0]  LinThrReset  = ThrW'(655);
  localparam logic [ThrW-1:0]  AngThrReset  = ThrW'(655);
  localparam logic [RunW-1:0]  ConfirmReset = RunW'(2);
  localparam logic [RateW-1:0] RateReset    = RateW'(65470);
  localparam logic [WinW-1:0]  WindowReset  = WinW'(130);

  typedef enum logic [CfgIdxW-1:0] {
    REG_LIN_THR  = 3'd0,
    REG_ANG_THR  = 3'd1,
    REG_CONFIRM  = 3'd2,
    REG_RATE     = 3'd3,
    REG_WINDOW   = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    MODE_ODOM = 1'b0,
    MODE_CMD  = 1'b1
  } mode_e;

  typedef struct packed {
    logic                    mode;
    logic signed [VelW-1:0]  linear_velocity;
    logic signed [VelW-1:0]  angular_velocity;
    logic [TimeW-1:0]        time_ms;
    logic                    transform_ready;
    logic                    target_in_view;
    logic [ScoreW-1:0]       last_score;
  } in_item_t;

  typedef struct packed {
    logic              moving;
    logic              state_changed;
    logic              best_score_valid;
    logic [ScoreW-1:0] best_score;
  } out_item_t;

  typedef struct packed {
    logic [ThrW-1:0]  linear_threshold;
    logic [ThrW-1:0]  angular_threshold;
    logic [RunW-1:0]  confirm_count;
    logic [RateW-1:0] decline_rate;
    logic [WinW-1:0]  command_window_ms;
  } cfg_t;

  typedef struct packed {
    logic             moving;
    logic [RunW-1:0]  stop_run;
    logic [RunW-1:0]  move_run;
    logic             ready_seen;
    logic             cmd_moving;
    logic [TimeW-1:0] cmd_time;
  } state_t;

  typedef struct packed {
    logic      has_result;
    state_t    next_state;
    out_item_t result;
  } judge_t;

endpackage

// ===== hw/rtl/msq_judge.sv =====
// Single-pass judgment of one sample against the qualifier state.
module msq_judge (
  input  msq_pkg::cfg_t     cfg_i,
  input  msq_pkg::state_t   state_i,
  input  msq_pkg::in_item_t item_i,
  output msq_pkg::judge_t   judge_o
);

  logic [msq_pkg::MagW-1:0]           lin_ext, ang_ext, lin_mag, ang_mag;
  logic                               still;
  logic [msq_pkg::RunW-1:0]           stop_bump, move_bump;
  logic [msq_pkg::TimeW-1:0]          elapsed;
  logic                               early;
  logic [msq_pkg::ScoreW+msq_pkg::RateW-1:0] prod;

  assign lin_ext = {item_i.linear_velocity[msq_pkg::VelW-1], item_i.linear_velocity};
  assign ang_ext = {item_i.angular_velocity[msq_pkg::VelW-1], item_i.angular_velocity};
  assign lin_mag = lin_ext[msq_pkg::MagW-1] ? (~lin_ext + msq_pkg::MagW'(1)) : lin_ext;
  assign ang_mag = ang_ext[msq_pkg::MagW-1] ? (~ang_ext + msq_pkg::MagW'(1)) : ang_ext;

  assign still = (lin_mag < msq_pkg::MagW'(cfg_i.linear_threshold)) &&
                 (ang_mag < msq_pkg::MagW'(cfg_i.angular_threshold));

  // saturate run counters at full scale
  assign stop_bump = (&state_i.stop_run) ? state_i.stop_run
                                         : state_i.stop_run + msq_pkg::RunW'(1);
  assign move_bump = (&state_i.move_run) ? state_i.move_run
                                         : state_i.move_run + msq_pkg::RunW'(1);

  assign elapsed = item_i.time_ms - state_i.cmd_time;
  assign early   = state_i.cmd_moving &&
                   (elapsed < msq_pkg::TimeW'(cfg_i.command_window_ms));

  assign prod = (msq_pkg::ScoreW+msq_pkg::RateW)'(item_i.last_score) *
                (msq_pkg::ScoreW+msq_pkg::RateW)'(cfg_i.decline_rate);

  always_comb begin
    judge_o = '0;
    judge_o.next_state = state_i;
    if (item_i.mode == msq_pkg::MODE_CMD) begin
      judge_o.next_state.cmd_moving = (lin_mag > msq_pkg::CmdMotionLimit) ||
                                      (ang_mag > msq_pkg::CmdMotionLimit);
      judge_o.next_state.cmd_time   = item_i.time_ms;
    end else if (!state_i.ready_seen) begin
      // wait for the transform; this sample is not judged
      judge_o.next_state.ready_seen = item_i.transform_ready;
    end else begin
      judge_o.has_result = 1'b1;
      if (still) begin
        judge_o.next_state.move_run = '0;
        if (state_i.moving) begin
          judge_o.next_state.stop_run = stop_bump;
          if (stop_bump >= cfg_i.confirm_count) begin
            judge_o.next_state.moving = 1'b0;
            if (item_i.target_in_view) begin
              judge_o.result.best_score_valid = 1'b1;
              judge_o.result.best_score =
                prod[msq_pkg::RateW +: msq_pkg::ScoreW];
            end
          end
        end
      end else begin
        judge_o.next_state.stop_run = '0;
        if (!state_i.moving) begin
          judge_o.next_state.move_run = move_bump;
          if ((move_bump >= cfg_i.confirm_count) || early) begin
            judge_o.next_state.moving = 1'b1;
          end
        end
      end
      judge_o.result.moving        = judge_o.next_state.moving;
      judge_o.result.state_changed = judge_o.next_state.moving != state_i.moving;
    end
  end

endmodule

// ===== hw/rtl/motion_state_qualifier.sv =====
// Top level of the motion state qualifier: handshake, registers and state.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  in      | request   | in_valid_i / in_stall_o  | in_data_i  (in_item_t)
//  out     | result    | out_valid_o / out_stall_i| out_data_o (out_item_t)
//  cfg     | write     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// One request per cycle while the result side does not stall: a request is
// accepted into the input register, judged there by the single-pass logic and
// written to the result register, from which its result is offered. Command
// requests and requests before the transform is ready give no result.
// Reset clears the motion state, run counters and command memory and loads
// the default configuration; there is no clearing pass.
// A stalled, full result register holds itself and the input register in the
// same cycle; the request side stalls once the input register holds a request
// as well, so one request can still be taken behind a stalled result.
module motion_state_qualifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  msq_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output msq_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [msq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [msq_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  msq_pkg::cfg_t      cfg_q;
  msq_pkg::state_t    st_q;
  logic               in_valid_q;
  msq_pkg::in_item_t  in_data_q;
  logic               out_valid_q;
  msq_pkg::out_item_t out_data_q;
  msq_pkg::judge_t    judge;
  logic               advance;

  // Move forward whenever the result register is free or being drained.
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = in_valid_q && !advance;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.linear_threshold  <= msq_pkg::LinThrReset;
      cfg_q.angular_threshold <= msq_pkg::AngThrReset;
      cfg_q.confirm_count     <= msq_pkg::ConfirmReset;
      cfg_q.decline_rate      <= msq_pkg::RateReset;
      cfg_q.command_window_ms <= msq_pkg::WindowReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        msq_pkg::REG_LIN_THR: cfg_q.linear_threshold  <= cfg_wdata_i[msq_pkg::ThrW-1:0];
        msq_pkg::REG_ANG_THR: cfg_q.angular_threshold <= cfg_wdata_i[msq_pkg::ThrW-1:0];
        msq_pkg::REG_CONFIRM: cfg_q.confirm_count     <= cfg_wdata_i[msq_pkg::RunW-1:0];
        msq_pkg::REG_RATE:    cfg_q.decline_rate      <= cfg_wdata_i[msq_pkg::RateW-1:0];
        msq_pkg::REG_WINDOW:  cfg_q.command_window_ms <= cfg_wdata_i[msq_pkg::WinW-1:0];
        default: ;
      endcase
    end
  end

  // Input register: load a new request whenever it is not stalled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_data_q <= in_data_i;
    end
  end

  msq_judge u_judge (
    .cfg_i   (cfg_q),
    .state_i (st_q),
    .item_i  (in_data_q),
    .judge_o (judge)
  );

  // Qualifier state advances once per request, as it leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (in_valid_q && advance) begin
      st_q <= judge.next_state;
    end
  end

  // Result register: hold while stalled, otherwise take the judged result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && judge.has_result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && judge.has_result) begin
      out_data_q <= judge.result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // A best score is only given on a switch to stopped.
  a_score_on_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.best_score_valid |->
      !out_data_o.moving && out_data_o.state_changed)
    else $error("best score given without a switch to stopped");

  // An absent best score reads as zero.
  a_score_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.best_score_valid |-> out_data_o.best_score == '0)
    else $error("best score nonzero while not valid");

  // Once the transform was seen, it stays seen.
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(st_q.ready_seen))
    else $error("ready flag dropped");

  // Request side stalls only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a stalled result");

  // A judged request always lands in the result register.
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && advance && judge.has_result |=> out_valid_q)
    else $error("judged result lost");

endmodule

// ===== dv/msq_state_monitor.sv =====
// Channel monitor for the motion state qualifier: predicts each result and compares it.
module msq_state_monitor
  import msq_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  in_item_t            in_data_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  out_item_t           out_data_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o,
  output int unsigned         results_o,
  output int unsigned         changes_o,
  output int unsigned         scores_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ReportLimit = 10;

  cfg_t        regs;
  state_t      motion;
  out_item_t   verdict_q[$];
  out_item_t   oldest;
  int unsigned fails;
  int unsigned results;
  int unsigned changes;
  int unsigned scores;

  function automatic logic [MagW-1:0] magnitude(logic [VelW-1:0] v);
    return v[VelW-1] ? (MagW'(1) << VelW) - MagW'(v) : MagW'(v);
  endfunction

  function automatic logic [RunW-1:0] count_up(logic [RunW-1:0] run);
    return (&run) ? run : run + 1'b1;
  endfunction

  task automatic compare_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fails++;
      if (fails <= ReportLimit)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  // Advance the motion state by one request; push a verdict for every judged sample.
  task automatic judge_request(input in_item_t req);
    logic [MagW-1:0]         lin_mag;
    logic [MagW-1:0]         ang_mag;
    logic [TimeW-1:0]        elapsed;
    logic [ScoreW+RateW-1:0] product;
    logic                    was_moving;
    out_item_t               res;
    lin_mag = magnitude(req.linear_velocity);
    ang_mag = magnitude(req.angular_velocity);
    if (req.mode == MODE_CMD) begin
      motion.cmd_moving = (lin_mag > CmdMotionLimit) || (ang_mag > CmdMotionLimit);
      motion.cmd_time   = req.time_ms;
    end else if (!motion.ready_seen) begin
      if (req.transform_ready)
        motion.ready_seen = 1'b1;
    end else begin
      res        = '0;
      was_moving = motion.moving;
      if (lin_mag < MagW'(regs.linear_threshold) && ang_mag < MagW'(regs.angular_threshold)) begin
        motion.move_run = '0;
        if (was_moving) begin
          motion.stop_run = count_up(motion.stop_run);
          if (motion.stop_run >= regs.confirm_count) begin
            motion.moving = 1'b0;
            if (req.target_in_view) begin
              product              = (ScoreW+RateW)'(req.last_score) *
                                     (ScoreW+RateW)'(regs.decline_rate);
              res.best_score_valid = 1'b1;
              res.best_score       = product[ScoreW+RateW-1:RateW];
            end
          end
        end
      end else begin
        motion.stop_run = '0;
        if (!was_moving) begin
          // a time earlier than the command wraps to a large elapsed value
          elapsed         = req.time_ms - motion.cmd_time;
          motion.move_run = count_up(motion.move_run);
          if (motion.move_run >= regs.confirm_count ||
              (motion.cmd_moving && elapsed < TimeW'(regs.command_window_ms)))
            motion.moving = 1'b1;
        end
      end
      res.moving        = motion.moving;
      res.state_changed = (was_moving != motion.moving);
      verdict_q.push_back(res);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs    = '{LinThrReset, AngThrReset, ConfirmReset, RateReset, WindowReset};
      motion  = '0;
      verdict_q.delete();
      fails   = 0;
      results = 0;
      changes = 0;
      scores  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      changes_o    <= 0;
      scores_o     <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          fails++;
          if (fails <= ReportLimit)
            $display("%0t: result with none expected: %p", $realtime, out_data_i);
        end else begin
          oldest = verdict_q.pop_front();
          compare_field("moving", oldest.moving, out_data_i.moving);
          compare_field("state_changed", oldest.state_changed, out_data_i.state_changed);
          compare_field("best_score_valid", oldest.best_score_valid,
                        out_data_i.best_score_valid);
          compare_field("best_score", oldest.best_score, out_data_i.best_score);
          results++;
          if (oldest.state_changed)
            changes++;
          if (oldest.best_score_valid)
            scores++;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          REG_LIN_THR: regs.linear_threshold  = cfg_wdata_i[ThrW-1:0];
          REG_ANG_THR: regs.angular_threshold = cfg_wdata_i[ThrW-1:0];
          REG_CONFIRM: regs.confirm_count     = cfg_wdata_i[RunW-1:0];
          REG_RATE:    regs.decline_rate      = cfg_wdata_i[RateW-1:0];
          REG_WINDOW:  regs.command_window_ms = cfg_wdata_i[WinW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        judge_request(in_data_i);
      fail_count_o <= fails;
      pending_o    <= verdict_q.size();
      results_o    <= results;
      changes_o    <= changes;
      scores_o     <= scores;
    end
  end

endmodule

// ===== dv/tb_motion_state_qualifier.sv =====
// Testbench top for the motion state qualifier: stimulus, idling phases and verdict.
module tb_motion_state_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  import msq_pkg::*;

  // Pause after the last expected result so trailing requests clear the pipeline.
  localparam int unsigned DrainPause    = 4;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned HangLimit     = 2000;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned PhaseRequests = 60;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned result_count;
  int unsigned change_count;
  int unsigned score_count;

  // Stimulus bookkeeping: the register image, the idling mix and the run shaping.
  cfg_t        active_cfg = '{LinThrReset, AngThrReset, ConfirmReset, RateReset, WindowReset};
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  logic [TimeW-1:0] now_ms = '0;
  bit          want_moving = 1'b0;
  int unsigned run_left    = 0;
  int unsigned sent_count  = 0;
  int unsigned cmd_count   = 0;
  int unsigned setting_count = 0;
  int unsigned quiet_cycles  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  motion_state_qualifier dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  msq_state_monitor u_monitor (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (result_count),
    .changes_o    (change_count),
    .scores_o     (score_count)
  );

  // Result side: stall at the rate of the current phase, re-rolled every cycle.
  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: count cycles in which neither channel completes a handshake.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == HangLimit) begin
      $display("Watchdog: no handshake for %0d cycles, %0d results outstanding",
               HangLimit, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request, after a random idle gap, and hold it until it is taken.
  task automatic send_req(input in_item_t req);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    sent_count++;
    if (req.mode == MODE_CMD)
      cmd_count++;
  endtask

  // Drop valid and hold off until every predicted result has arrived,
  // then let trailing no-result requests clear the pipeline.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DrainPause) @(posedge clk);
  endtask

  function automatic logic [CfgDataW-1:0] reg_value(cfg_t c, cfg_idx_e r);
    case (r)
      REG_LIN_THR: return CfgDataW'(c.linear_threshold);
      REG_ANG_THR: return CfgDataW'(c.angular_threshold);
      REG_CONFIRM: return CfgDataW'(c.confirm_count);
      REG_RATE:    return CfgDataW'(c.decline_rate);
      REG_WINDOW:  return CfgDataW'(c.command_window_ms);
      default:     return '0;
    endcase
  endfunction

  // Write every register, back to back, keeping the write enable high throughout.
  task automatic apply_cfg(input cfg_t c);
    cfg_idx_e r;
    r = r.first();
    do begin
      cfg_we    <= 1'b1;
      cfg_idx   <= r;
      cfg_wdata <= reg_value(c, r);
      @(posedge clk);
      r = r.next();
    end while (r != r.first());
    cfg_we     <= 1'b0;
    active_cfg  = c;
    setting_count++;
  endtask

  function automatic in_item_t odom_req(logic [VelW-1:0] lin, logic [VelW-1:0] ang,
                                        logic [TimeW-1:0] t, logic ready, logic visible,
                                        logic [ScoreW-1:0] score);
    in_item_t r;
    r.mode             = MODE_ODOM;
    r.linear_velocity  = lin;
    r.angular_velocity = ang;
    r.time_ms          = t;
    r.transform_ready  = ready;
    r.target_in_view   = visible;
    r.last_score       = score;
    return r;
  endfunction

  // Command requests carry random filler in the fields the block ignores.
  function automatic in_item_t cmd_req(logic [VelW-1:0] lin, logic [VelW-1:0] ang,
                                       logic [TimeW-1:0] t);
    in_item_t r;
    r      = odom_req(lin, ang, t, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      ScoreW'($urandom));
    r.mode = MODE_CMD;
    return r;
  endfunction

  // Pick a velocity of magnitude >= limit (over), else < limit (or 0 if limit is 0).
  function automatic logic [VelW-1:0] pick_vel(logic [ThrW-1:0] limit, bit over);
    logic [MagW-1:0] mag;
    logic [VelW-1:0] raw;
    if (over) begin
      case ($urandom_range(2))
        0:       mag = MagW'(limit) + MagW'($urandom_range(2));
        1:       mag = MagW'(limit) + MagW'($urandom_range(65535));
        default: begin
          raw = $urandom;
          mag = raw[VelW-1] ? (MagW'(1) << VelW) - MagW'(raw) : MagW'(raw);
          if (mag < MagW'(limit))
            mag = MagW'(limit);
        end
      endcase
    end else begin
      mag = (limit == 0) ? '0 : MagW'($urandom_range(limit - 1, 0));
    end
    raw = mag[VelW-1:0];
    return $urandom_range(1) ? -raw : raw;
  endfunction

  // One random request: mostly odometry runs shaped around the confirm count,
  // with commands and unstructured noise mixed in.
  task automatic send_random_req();
    int unsigned roll;
    int unsigned axis;
    int unsigned run_cap;
    bit          over;
    in_item_t    r;
    roll = $urandom_range(99);
    axis = $urandom_range(2);
    if ($urandom_range(19) == 0)
      now_ms = $urandom;
    else
      now_ms += $urandom_range(80);
    if (roll < 15) begin
      r.mode             = 1'($urandom_range(1));
      r.linear_velocity  = $urandom;
      r.angular_velocity = $urandom;
      r.time_ms          = $urandom;
      r.transform_ready  = 1'($urandom_range(1));
      r.target_in_view   = 1'($urandom_range(1));
      r.last_score       = ScoreW'($urandom);
    end else if (roll < 27) begin
      over = 1'($urandom_range(1));
      r = cmd_req(pick_vel(ThrW'(CmdMotionLimit + 1), over && axis != 1),
                  pick_vel(ThrW'(CmdMotionLimit + 1), over && axis != 0), now_ms);
    end else begin
      if (run_left == 0) begin
        want_moving = !want_moving;
        run_cap     = (active_cfg.confirm_count > 6) ? 8 : active_cfg.confirm_count + 2;
        run_left    = $urandom_range(run_cap, 1);
      end
      run_left--;
      r = odom_req(pick_vel(active_cfg.linear_threshold, want_moving && axis != 1),
                   pick_vel(active_cfg.angular_threshold, want_moving && axis != 0),
                   now_ms, 1'($urandom_range(1)), 1'($urandom_range(1)),
                   ScoreW'($urandom));
    end
    send_req(r);
  endtask

  initial begin
    cfg_t next_cfg;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: nothing is judged before the transform is ready.
    send_req(odom_req(0, 0, 100, 1'b0, 1'b0, '0));
    send_req(cmd_req(1000, 0, 100));
    send_req(odom_req(5000, 0, 110, 1'b1, 1'b0, '0));
    // First judged sample; extreme velocities start a move run.
    send_req(odom_req(0, 0, 120, 1'b0, 1'b1, 18'h3FFFF));
    send_req(odom_req(32'h8000_0000, 32'h7FFF_FFFF, 400, 1'b0, 1'b0, '0));
    // Magnitude equal to the threshold counts as motion; second one confirms.
    send_req(odom_req(655, 0, 401, 1'b0, 1'b0, '0));
    // Stop with the marker visible and the largest score.
    send_req(odom_req(-654, 654, 402, 1'b1, 1'b1, 18'h3FFFF));
    send_req(odom_req(0, -654, 403, 1'b0, 1'b1, 18'h3FFFF));
    // Recent moving command forces an early switch just inside the window.
    send_req(cmd_req(-656, 0, 500));
    send_req(odom_req(0, 32'h7FFF_FFFF, 629, 1'b0, 1'b0, '0));
    // Stop with the marker hidden: no score.
    send_req(odom_req(0, 0, 630, 1'b0, 1'b0, 18'h1));
    send_req(odom_req(1, -1, 631, 1'b1, 1'b0, 18'h3FFFF));
    // Command window across the wrap of the millisecond counter.
    send_req(cmd_req(2000, 32'h8000_0000, 32'hFFFF_FFF0));
    send_req(odom_req(-2000, 0, 32'h10, 1'b0, 1'b0, '0));
    send_req(odom_req(0, 0, 32'h11, 1'b0, 1'b1, '0));
    send_req(odom_req(0, 0, 32'h12, 1'b0, 1'b1, '0));
    // Command exactly at the motion limit is not a moving command.
    send_req(cmd_req(655, -655, 50));
    send_req(odom_req(-655, 0, 51, 1'b0, 1'b0, '0));
    send_req(odom_req(0, 0, 52, 1'b0, 1'b0, '0));
    // Odometry time earlier than the command: no early switch.
    send_req(cmd_req(3000, 0, 1000));
    send_req(odom_req(0, 0, 995, 1'b0, 1'b0, '0));
    send_req(odom_req(0, 700, 990, 1'b0, 1'b0, '0));
    send_req(odom_req(0, 700, 991, 1'b0, 1'b0, '0));

    // Random phases: new register settings each time; the four idling mixes take turns.
    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      next_cfg.linear_threshold  = ThrW'($urandom_range(4000));
      next_cfg.angular_threshold = ThrW'($urandom_range(4000));
      next_cfg.confirm_count     = RunW'($urandom_range(5, 1));
      next_cfg.decline_rate      = RateW'($urandom);
      next_cfg.command_window_ms = WinW'($urandom_range(300));
      case (p)
        0: next_cfg = '{'0, '0, RunW'(1), '0, '0};
        1: next_cfg = '{'1, '1, '1, '1, '1};
        2: next_cfg.confirm_count = '0;
        default: ;
      endcase
      apply_cfg(next_cfg);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      for (int n = 0; n < PhaseRequests; n++) begin
        // once, mid-phase: hold off until the pipeline is empty
        if (p == 3 && n == PhaseRequests / 2)
          drain_results();
        send_random_req();
      end
    end

    drain_results();
    $display("Sent %0d requests (%0d commands) under %0d register settings.",
             sent_count, cmd_count, setting_count + 1);
    $display("Checked %0d results with %0d state changes and %0d decayed scores.",
             result_count, change_count, score_count);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/msq_pkg.sv
hw/rtl/msq_judge.sv
hw/rtl/motion_state_qualifier.sv
dv/msq_state_monitor.sv
dv/tb_motion_state_qualifier.sv
